// ===== hdl/sgt_pkg.sv =====
package sgt_pkg;

  // Receive window size in slots and kept handle width.
  localparam int WINDOW      = 32;
  localparam int HANDLE_BITS = 16;

  // Port widths fixed by the interface.
  localparam int SEQ_W    = 64;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 3;

  // Derived sizes.
  localparam int SLOT_W    = $clog2(WINDOW);
  localparam int SH_W      = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int RAM_AW    = SLOT_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd4;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } sgt_op_t;

  // One decoded item as it travels from the front queue to the back.
  typedef struct packed {
    sgt_op_t           op;
    logic              urgent;
    logic [SEQ_W-1:0]  seq;
    logic [SH_W-1:0]   handle;
  } sgt_item_t;

endpackage

// ===== hdl/sgt_ram.sv =====
module sgt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/sgt_front.sv =====
module sgt_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic                        urgent,
  input  logic [sgt_pkg::SEQ_W-1:0]    seq_number,
  input  logic [sgt_pkg::HANDLE_W-1:0] txn_handle,
  output sgt_pkg::sgt_item_t          head,
  output logic                        head_valid,
  input  logic                        pop
);
  import sgt_pkg::*;

  // Two-entry queue that decouples acceptance from execution.
  sgt_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  sgt_item_t  item_in;

  always_comb begin
    item_in.op     = cmd ? OP_LOOKUP : OP_ADD;
    item_in.urgent = urgent;
    item_in.seq    = seq_number;
    item_in.handle = SH_W'(txn_handle);
  end

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head       = slots[rd_ptr];
  assign head_valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

endmodule

// ===== hdl/sgt_back.sv =====
module sgt_back (
  input  logic                        clk,
  input  logic                        rst,
  input  sgt_pkg::sgt_item_t          head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sgt_pkg::STATUS_W-1:0] status,
  output logic [sgt_pkg::HANDLE_W-1:0] handle_out,
  output logic [sgt_pkg::SEQ_W-1:0]    gap_number,
  output logic                        gap_valid,
  output logic                        last
);
  import sgt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLASS = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_ADV   = 7'b0010000,
    S_SPAN  = 7'b0100000,
    S_GAP   = 7'b1000000
  } state_t;

  localparam logic [SLOT_W-1:0] SLOT_INIT = SLOT_W'(1 % WINDOW);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(WINDOW - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  state_t state, state_next;

  // Per-class window state; mslot is the slot of mark + 1.
  logic [SEQ_W-1:0]  mark         [2];
  logic [SEQ_W-1:0]  mark_next    [2];
  logic [SLOT_W-1:0] mslot        [2];
  logic [SLOT_W-1:0] mslot_next   [2];
  logic [WINDOW-1:0] present      [2];
  logic [WINDOW-1:0] present_next [2];

  sgt_item_t         itm, itm_next;
  logic [SEQ_W-1:0]  diff, diff_next;
  logic              le, le_next;
  logic [SEQ_W-1:0]  gap_i, gap_i_next;
  logic [SLOT_W-1:0] gap_slot, gap_slot_next;
  logic [SLOT_W-1:0] gap_left, gap_left_next;
  logic              pend_valid, pend_valid_next;
  logic [SEQ_W-1:0]  pend_num, pend_num_next;

  logic                out_valid_next;
  logic                emit;
  logic [STATUS_W-1:0] e_status;
  logic [HANDLE_W-1:0] e_handle;
  logic [SEQ_W-1:0]    e_gap;
  logic                e_gv;
  logic                e_last;
  logic                can_emit;

  logic              cls;
  logic [SLOT_W-1:0] dm1;
  logic [SLOT_W:0]   ssum;
  logic [SLOT_W-1:0] eslot;
  logic              beyond;
  logic [SEQ_W-1:0]  span;

  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [RAM_AW-1:0] ram_addr;
  logic [SH_W-1:0]   ram_rd_data;

  assign cls      = itm.urgent;
  assign can_emit = !out_valid || !out_stall;

  // Slot of the item's number: mark slot plus (diff - 1), wrapped once.
  assign dm1    = diff[SLOT_W-1:0] - SLOT_W'(1);
  assign ssum   = {1'b0, mslot[cls]} + {1'b0, dm1};
  assign eslot  = (ssum >= (SLOT_W + 1)'(WINDOW)) ?
                  SLOT_W'(ssum - (SLOT_W + 1)'(WINDOW)) : ssum[SLOT_W-1:0];
  assign beyond = (diff > SEQ_W'(WINDOW));
  assign span   = itm.seq - mark[cls];

  assign ram_addr = {cls, eslot};

  sgt_ram #(
    .WIDTH (SH_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_addr),
    .wr_data (itm.handle),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_next      = state;
    mark_next       = mark;
    mslot_next      = mslot;
    present_next    = present;
    itm_next        = itm;
    diff_next       = diff;
    le_next         = le;
    gap_i_next      = gap_i;
    gap_slot_next   = gap_slot;
    gap_left_next   = gap_left;
    pend_valid_next = pend_valid;
    pend_num_next   = pend_num;
    pop             = 1'b0;
    ram_wr_en       = 1'b0;
    ram_rd_en       = 1'b0;
    emit            = 1'b0;
    e_status        = ST_OK;
    e_handle        = '0;
    e_gap           = '0;
    e_gv            = 1'b0;
    e_last          = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          itm_next   = head;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        diff_next  = itm.seq - mark[cls];
        le_next    = (itm.seq <= mark[cls]);
        state_next = S_EVAL;
      end
      S_EVAL: begin
        priority if (le) begin
          if (can_emit) begin
            emit       = 1'b1;
            e_status   = (itm.op == OP_LOOKUP) ? ST_DELIVERED : ST_DUP;
            state_next = S_IDLE;
          end
        end else if (beyond) begin
          if (can_emit) begin
            emit       = 1'b1;
            e_status   = ST_BEYOND;
            state_next = S_IDLE;
          end
        end else if (itm.op == OP_LOOKUP) begin
          if (present[cls][eslot]) begin
            ram_rd_en  = 1'b1;
            state_next = S_READ;
          end else if (can_emit) begin
            emit       = 1'b1;
            e_status   = ST_ABSENT;
            state_next = S_IDLE;
          end
        end else if (present[cls][eslot]) begin
          if (can_emit) begin
            emit       = 1'b1;
            e_status   = ST_DUP;
            state_next = S_IDLE;
          end
        end else begin
          ram_wr_en                = 1'b1;
          present_next[cls][eslot] = 1'b1;
          state_next               = S_ADV;
        end
      end
      S_READ: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_handle   = HANDLE_W'(ram_rd_data);
          state_next = S_IDLE;
        end
      end
      S_ADV: begin
        // Retire one present slot per cycle above the mark.
        if ((mark[cls] != '1) && present[cls][mslot[cls]]) begin
          present_next[cls][mslot[cls]] = 1'b0;
          mark_next[cls]                = mark[cls] + SEQ_W'(1);
          mslot_next[cls]               = slot_inc(mslot[cls]);
        end else begin
          state_next = S_SPAN;
        end
      end
      S_SPAN: begin
        gap_i_next      = mark[cls] + SEQ_W'(1);
        gap_slot_next   = mslot[cls];
        gap_left_next   = (itm.seq > mark[cls]) ?
                          SLOT_W'(span[SLOT_W-1:0] - SLOT_W'(1)) : '0;
        pend_valid_next = 1'b0;
        state_next      = S_GAP;
      end
      S_GAP: begin
        // A found gap is held one step so the final one can carry last.
        if (gap_left == '0) begin
          if (can_emit) begin
            emit            = 1'b1;
            e_gv            = pend_valid;
            e_gap           = pend_valid ? pend_num : '0;
            pend_valid_next = 1'b0;
            state_next      = S_IDLE;
          end
        end else if (!present[cls][gap_slot] && pend_valid && !can_emit) begin
          state_next = S_GAP;
        end else begin
          if (!present[cls][gap_slot]) begin
            if (pend_valid) begin
              emit   = 1'b1;
              e_gv   = 1'b1;
              e_gap  = pend_num;
              e_last = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_num_next   = gap_i;
          end
          gap_i_next    = gap_i + SEQ_W'(1);
          gap_slot_next = slot_inc(gap_slot);
          gap_left_next = gap_left - SLOT_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = emit || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mark[0]    <= '0;
      mark[1]    <= '0;
      mslot[0]   <= SLOT_INIT;
      mslot[1]   <= SLOT_INIT;
      present[0] <= '0;
      present[1] <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      mark       <= mark_next;
      mslot      <= mslot_next;
      present    <= present_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    itm      <= itm_next;
    diff     <= diff_next;
    le       <= le_next;
    gap_i    <= gap_i_next;
    gap_slot <= gap_slot_next;
    gap_left <= gap_left_next;
    pend_num <= pend_num_next;
    if (emit) begin
      status     <= e_status;
      handle_out <= e_handle;
      gap_number <= e_gap;
      gap_valid  <= e_gv;
      last       <= e_last;
    end
  end

  // The contiguous mark of either class never moves backward.
  a_mark_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (mark[0] >= $past(mark[0])) && (mark[1] >= $past(mark[1])))
    else $error("contiguous mark decreased");

  // Once advancing ends, the slot above the mark is empty unless the mark is saturated.
  a_adv_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPAN) |-> ((mark[cls] == '1) || !present[cls][mslot[cls]]))
    else $error("advance stopped on a present slot");

  // A held gap is always below the number currently being scanned.
  a_pend_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_GAP) && pend_valid |-> (pend_num < gap_i))
    else $error("held gap out of order");

  // The handle memory is read only for a lookup that found its slot present.
  a_rd_lookup: assert property (@(posedge clk) disable iff (rst)
    ram_rd_en |-> (state == S_EVAL) && (itm.op == OP_LOOKUP) && present[cls][eslot])
    else $error("handle read outside a present lookup");

endmodule

// ===== hdl/sequence_gap_tracker_unit.sv =====
// Flow: an accepted item leaves the queue and passes through the classify and evaluate states;
// a lookup that reads a stored handle also passes through the read state, and an add then
// retires slots above the mark (up to WINDOW), spans and scans the numbers up to its own.
// Throughput: the back end runs one item at a time, and output stalls hold it.
// Reset clears both marks, the present bits, the queue and out_valid; handles stay uncleared.
module sequence_gap_tracker_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic                        urgent,
  input  logic [sgt_pkg::SEQ_W-1:0]    seq_number,
  input  logic [sgt_pkg::HANDLE_W-1:0] txn_handle,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sgt_pkg::STATUS_W-1:0] status,
  output logic [sgt_pkg::HANDLE_W-1:0] handle_out,
  output logic [sgt_pkg::SEQ_W-1:0]    gap_number,
  output logic                        gap_valid,
  output logic                        last
);
  import sgt_pkg::*;

  // The front end decodes each accepted item and parks it in a two-entry
  // queue, so a new item can be taken while the back end is still busy
  // retiring slots or streaming gap results.
  sgt_item_t head;
  logic      head_valid;
  logic      pop;

  sgt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .urgent     (urgent),
    .seq_number (seq_number),
    .txn_handle (txn_handle),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // The back end owns the per-class window state and the handle memory.
  // It classifies each item against the mark, stores or reads the handle,
  // advances the mark one slot per cycle and then scans the window for
  // missing numbers, delivering them through a single output register.
  sgt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .handle_out (handle_out),
    .gap_number (gap_number),
    .gap_valid  (gap_valid),
    .last       (last)
  );

endmodule
